// ===== hw/rtl/sbsu_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsu_pkg
// Shared types and constants of the strip background subtract and update block.
// ----------------------------------------------------------------------------
package sbsu_pkg;

  localparam int unsigned STRIP_BYTES_MAX = 32768;
  localparam int unsigned IDX_W           = $clog2(STRIP_BYTES_MAX);

  typedef logic [IDX_W-1:0] pos_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DIFF_THRESHOLD     = 2'd0,
    CFG_VEHICLE_FREE_LIMIT = 2'd1,
    CFG_QUIET_RUN_TARGET   = 2'd2
  } cfg_index_e;

  localparam logic [7:0]  DIFF_THRESHOLD_RST     = 8'd15;
  localparam logic [15:0] VEHICLE_FREE_LIMIT_RST = 16'd1;
  localparam logic [7:0]  QUIET_RUN_TARGET_RST   = 8'd149;

  localparam logic [7:0] QUIET_COUNT_MAX  = 8'd255;
  localparam logic [7:0] SAMPLE_FIRST_CNT = 8'd30;
  localparam logic [7:0] SAMPLE_ADD_CNT_A = 8'd60;
  localparam logic [7:0] SAMPLE_ADD_CNT_B = 8'd90;
  localparam logic [7:0] SAMPLE_ADD_CNT_C = 8'd120;

  // what the current frame does with the accumulator and the background
  typedef struct packed {
    logic commit;
    logic first;
    logic add;
  } slot_t;

endpackage

// ===== hw/rtl/sbsu_ram.sv =====
// ----------------------------------------------------------------------------
// sbsu_ram
// Generic single write port, single read port RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sbsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/strip_background_subtract_update.sv =====
// ----------------------------------------------------------------------------
// strip_background_subtract_update
// Background subtraction on strip image bytes with a background learned from
// runs of quiet frames.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one pixel byte per item with func, first_of_frame and, on the
//                 first byte of a frame, vehicle_signal and frame_number.
//   out channel : one result item per input item, in order.
//   cfg channel : register index and data, always ready; write only while idle.
// out_valid_o is registered behind the processing stage and the output
// register. Throughput is one item per clock while the output is not stalled,
// set by the single read-modify-write per byte on the background
// and accumulator RAMs (read at acceptance, written as the item leaves).
// After reset the background RAM is cleared one entry per cycle, all 32768
// entries, with in_ready_o low; configuration writes are taken meanwhile.
// When the receiver stalls the output register holds its result, one more
// item is taken into the processing stage, then in_ready_o drops.
// ----------------------------------------------------------------------------
module strip_background_subtract_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  pixel_byte_i,
  input  logic        first_of_frame_i,
  input  logic [15:0] vehicle_signal_i,
  input  logic [31:0] frame_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  masked_byte_o,
  output logic        background_replaced_o,
  output logic [7:0]  quiet_run_o
);

  // configuration
  logic [7:0]  diff_threshold_q;
  logic [15:0] vehicle_free_limit_q;
  logic [7:0]  quiet_run_target_q;

  // frame state
  sbsu_pkg::pos_t  byte_index_q;
  logic [7:0]      quiet_count_q;
  logic [31:0]     frame_number_q;
  sbsu_pkg::slot_t slot_q;

  // clearing pass
  logic           clr_active_q;
  sbsu_pkg::pos_t clr_addr_q;

  // processing stage
  logic            s1_valid_q;
  logic            s1_func_q;
  logic [7:0]      s1_pix_q;
  sbsu_pkg::pos_t  s1_pos_q;
  sbsu_pkg::slot_t s1_slot_q;
  logic [7:0]      s1_count_q;

  // write forwarding from the previous item
  logic           bg_fwd_valid_q;
  sbsu_pkg::pos_t bg_fwd_addr_q;
  logic [7:0]     bg_fwd_data_q;
  logic           acc_fwd_valid_q;
  sbsu_pkg::pos_t acc_fwd_addr_q;
  logic [7:0]     acc_fwd_data_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_masked_q;
  logic       out_replaced_q;
  logic [7:0] out_count_q;

  logic            in_accept;
  logic            s1_fire;
  sbsu_pkg::pos_t  in_pos;
  logic            frame_start;
  logic [7:0]      base_count;
  logic            frame_quiet;
  logic [7:0]      new_count;
  sbsu_pkg::slot_t new_slot;

  logic [7:0]     bg_rdata;
  logic [7:0]     acc_rdata;
  logic [7:0]     bg_cur;
  logic [7:0]     acc_cur;
  logic [7:0]     pix_quarter;
  logic [7:0]     diff;
  logic [7:0]     masked;
  logic [7:0]     acc_new;
  logic           s1_acc_we;
  logic           s1_bg_we;
  logic [7:0]     s1_bg_wdata;
  logic           bg_we;
  sbsu_pkg::pos_t bg_waddr;
  logic [7:0]     bg_wdata;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !clr_active_q && (!s1_valid_q || s1_fire);
  assign in_accept   = in_valid_i && in_ready_o;
  assign frame_start = in_accept && !func_i && first_of_frame_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_threshold_q     <= sbsu_pkg::DIFF_THRESHOLD_RST;
      vehicle_free_limit_q <= sbsu_pkg::VEHICLE_FREE_LIMIT_RST;
      quiet_run_target_q   <= sbsu_pkg::QUIET_RUN_TARGET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbsu_pkg::CFG_DIFF_THRESHOLD:     diff_threshold_q     <= cfg_data_i[7:0];
        sbsu_pkg::CFG_VEHICLE_FREE_LIMIT: vehicle_free_limit_q <= cfg_data_i;
        sbsu_pkg::CFG_QUIET_RUN_TARGET:   quiet_run_target_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // byte position of the incoming item
  always_comb begin
    if (first_of_frame_i) begin
      in_pos = '0;
    end else if (byte_index_q == sbsu_pkg::pos_t'(sbsu_pkg::STRIP_BYTES_MAX - 1)) begin
      in_pos = '0;
    end else begin
      in_pos = byte_index_q + sbsu_pkg::pos_t'(1);
    end
  end

  // frame decision, taken on the first detect byte of a frame
  always_comb begin
    base_count  = slot_q.commit ? 8'd0 : quiet_count_q;
    frame_quiet = (vehicle_signal_i < vehicle_free_limit_q) &&
                  (frame_number_i == frame_number_q + 32'd1);
    if (!frame_quiet) begin
      new_count = 8'd0;
    end else if (base_count == sbsu_pkg::QUIET_COUNT_MAX) begin
      new_count = base_count;
    end else begin
      new_count = base_count + 8'd1;
    end
    new_slot.first  = (new_count == sbsu_pkg::SAMPLE_FIRST_CNT);
    new_slot.add    = !new_slot.first &&
                      ((new_count == sbsu_pkg::SAMPLE_ADD_CNT_A) ||
                       (new_count == sbsu_pkg::SAMPLE_ADD_CNT_B) ||
                       (new_count == sbsu_pkg::SAMPLE_ADD_CNT_C));
    new_slot.commit = (new_count != 8'd0) && (new_count == quiet_run_target_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      quiet_count_q  <= '0;
      frame_number_q <= '0;
      slot_q         <= '0;
    end else begin
      if (in_accept) begin
        byte_index_q <= in_pos;
      end
      if (frame_start) begin
        quiet_count_q  <= new_count;
        frame_number_q <= frame_number_i;
        slot_q         <= new_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + sbsu_pkg::pos_t'(1);
      if (clr_addr_q == sbsu_pkg::pos_t'(sbsu_pkg::STRIP_BYTES_MAX - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q  <= func_i;
      s1_pix_q   <= pixel_byte_i;
      s1_pos_q   <= in_pos;
      s1_slot_q  <= frame_start ? new_slot : slot_q;
      s1_count_q <= frame_start ? new_count : quiet_count_q;
    end
  end

  // memories read at acceptance, written when the item leaves the stage (background also by the clearing pass)
  sbsu_ram #(
    .Width (8),
    .Depth (sbsu_pkg::STRIP_BYTES_MAX)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (bg_we),
    .waddr_i (bg_waddr),
    .wdata_i (bg_wdata),
    .re_i    (in_accept),
    .raddr_i (in_pos),
    .rdata_o (bg_rdata)
  );

  sbsu_ram #(
    .Width (8),
    .Depth (sbsu_pkg::STRIP_BYTES_MAX)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (s1_acc_we),
    .waddr_i (s1_pos_q),
    .wdata_i (acc_new),
    .re_i    (in_accept),
    .raddr_i (in_pos),
    .rdata_o (acc_rdata)
  );

  always_comb begin
    bg_cur  = (bg_fwd_valid_q && (bg_fwd_addr_q == s1_pos_q)) ? bg_fwd_data_q : bg_rdata;
    acc_cur = (acc_fwd_valid_q && (acc_fwd_addr_q == s1_pos_q)) ? acc_fwd_data_q : acc_rdata;
    pix_quarter = {2'b00, s1_pix_q[7:2]};
    diff = (s1_pix_q > bg_cur) ? (s1_pix_q - bg_cur) : (bg_cur - s1_pix_q);
    masked = (s1_func_q || (diff < diff_threshold_q)) ? 8'd0 : s1_pix_q;
    if (s1_slot_q.first) begin
      acc_new = pix_quarter;
    end else if (s1_slot_q.add) begin
      acc_new = acc_cur + pix_quarter;
    end else begin
      acc_new = acc_cur;
    end
    s1_acc_we   = s1_fire && !s1_func_q && (s1_slot_q.first || s1_slot_q.add);
    s1_bg_we    = s1_fire && (s1_func_q || s1_slot_q.commit);
    s1_bg_wdata = s1_func_q ? s1_pix_q : acc_new;
    // clearing pass owns the write port until it is done
    bg_we    = clr_active_q || s1_bg_we;
    bg_waddr = clr_active_q ? clr_addr_q : s1_pos_q;
    bg_wdata = clr_active_q ? 8'd0 : s1_bg_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_fwd_valid_q  <= 1'b0;
      acc_fwd_valid_q <= 1'b0;
    end else if (s1_fire) begin
      bg_fwd_valid_q  <= s1_bg_we;
      acc_fwd_valid_q <= s1_acc_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      bg_fwd_addr_q  <= s1_pos_q;
      bg_fwd_data_q  <= s1_bg_wdata;
      acc_fwd_addr_q <= s1_pos_q;
      acc_fwd_data_q <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_masked_q   <= masked;
      out_replaced_q <= !s1_func_q && s1_slot_q.commit;
      out_count_q    <= s1_count_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign masked_byte_o         = out_masked_q;
  assign background_replaced_o = out_replaced_q;
  assign quiet_run_o           = out_count_q;

endmodule
